[design/otm_pkg.sv]
`default_nettype none
package otm_pkg;

  localparam int OTM_COORD_BITS = 16;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [1:0] MODE_POINT  = 2'd0;
  localparam logic [1:0] MODE_REGION = 2'd1;
  localparam logic [1:0] MODE_DIMS   = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_C01    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_C23    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEL    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DTHR   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BTHR   = 3'd6;

  // orientation codes
  localparam logic [1:0] ORI_COL = 2'd0;
  localparam logic [1:0] ORI_POS = 2'd1;
  localparam logic [1:0] ORI_NEG = 2'd2;

  localparam logic [16:0] SAT_LIMIT = 17'h10000;

  typedef struct packed {
    logic [1:0]       mode;
    logic [15:0]      tx;
    logic [15:0]      ty;
    logic [15:0]      tz;
    logic [3:0][15:0] cx;
    logic [3:0][15:0] cy;
    logic [15:0]      sx;
    logic [15:0]      sy;
    logic [15:0]      sz;
    logic [15:0]      dthr;
    logic [15:0]      bthr;
  } cfg_t;

  typedef struct packed {
    logic [3:0]      onseg_p;
    logic [3:0]      onseg_far;
    logic [3:0][1:0] ycode;
    logic [3:0]      ray_on;
    logic            dims_ok;
  } geo_flags_t;

  typedef struct packed {
    logic [3:0] hit;
    logic [3:0] col;
    logic [3:0] onseg;
    logic       point_ok;
    logic       dims_ok;
  } eval_t;

  typedef struct packed {
    logic [7:0] index;
    logic       last;
  } tag_t;

endpackage
`default_nettype wire

[design/otm_if.sv]
`default_nettype none
interface obj_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [15:0]                  dim_x;
  logic [15:0]                  dim_y;
  logic [15:0]                  dim_z;
  logic [7:0]                   object_index;
  logic                         last_object;

  modport source (output valid, pos_x, pos_y, pos_z, dim_x, dim_y, dim_z,
                  object_index, last_object, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, dim_x, dim_y, dim_z,
                object_index, last_object, output ready);
endinterface

interface res_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [7:0] index_out;
  logic       last_out;

  modport source (output valid, matched, index_out, last_out, input ready);
  modport sink (input valid, matched, index_out, last_out, output ready);
endinterface
`default_nettype wire

[design/otm_regs.sv]
`default_nettype none
module otm_regs
  import otm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:   cfg.mode <= cfg_data[1:0];
        REG_TARGET: begin
          cfg.tx <= cfg_data[15:0];
          cfg.ty <= cfg_data[31:16];
          cfg.tz <= cfg_data[47:32];
        end
        REG_C01: begin
          cfg.cx[0] <= cfg_data[15:0];
          cfg.cy[0] <= cfg_data[31:16];
          cfg.cx[1] <= cfg_data[47:32];
          cfg.cy[1] <= cfg_data[63:48];
        end
        REG_C23: begin
          cfg.cx[2] <= cfg_data[15:0];
          cfg.cy[2] <= cfg_data[31:16];
          cfg.cx[3] <= cfg_data[47:32];
          cfg.cy[3] <= cfg_data[63:48];
        end
        REG_SEL: begin
          cfg.sx <= cfg_data[15:0];
          cfg.sy <= cfg_data[31:16];
          cfg.sz <= cfg_data[47:32];
        end
        REG_DTHR:   cfg.dthr <= cfg_data[15:0];
        REG_BTHR:   cfg.bthr <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/otm_diff.sv]
`default_nettype none
module otm_diff
  import otm_pkg::*;
#(
  parameter int COORD_BITS = OTM_COORD_BITS,
  localparam int CMAX = (COORD_BITS > 16) ? COORD_BITS : 16,
  localparam int PW = CMAX + 2,
  localparam int DW = PW + 1
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  cfg_t                              cfg,
  input  wire logic signed [COORD_BITS-1:0] pos_x,
  input  wire logic signed [COORD_BITS-1:0] pos_y,
  input  wire logic signed [COORD_BITS-1:0] pos_z,
  input  wire logic [15:0]                  dim_x,
  input  wire logic [15:0]                  dim_y,
  input  wire logic [15:0]                  dim_z,
  output logic [16:0]                       sq_mag [3],
  output logic signed [DW-1:0]              ex [4],
  output logic signed [DW-1:0]              ey [4],
  output logic signed [DW-1:0]              ax [4],
  output logic signed [DW-1:0]              fx [4],
  output logic signed [DW-1:0]              by [4],
  output geo_flags_t                        flags
);

  logic signed [PW-1:0] px, py, far_x;
  logic signed [PW-1:0] pe [3];
  logic signed [PW-1:0] te [3];
  logic signed [PW-1:0] cxe [4];
  logic signed [PW-1:0] cye [4];
  logic signed [DW-1:0] pd [3];
  logic [DW-1:0]        pm [3];
  logic [16:0]          sq_next [3];
  logic signed [DW-1:0] ex_next [4], ey_next [4], ax_next [4], fx_next [4], by_next [4];
  geo_flags_t           flags_next;

  function automatic logic close_dim(input logic [15:0] a, input logic [15:0] b,
                                     input logic [15:0] thr);
    logic [15:0] d;
    d = (a > b) ? a - b : b - a;
    return d < thr;
  endfunction

  always_comb begin
    px    = PW'(pos_x);
    py    = PW'(pos_y);
    far_x = {{(PW-COORD_BITS-1){1'b0}}, 1'b1, {COORD_BITS{1'b0}}};
    pe[0] = px;
    pe[1] = py;
    pe[2] = PW'(pos_z);
    te[0] = PW'($signed(cfg.tx));
    te[1] = PW'($signed(cfg.ty));
    te[2] = PW'($signed(cfg.tz));
    for (int k = 0; k < 3; k++) begin
      pd[k] = DW'(pe[k]) - DW'(te[k]);
      pm[k] = pd[k][DW-1] ? DW'(-pd[k]) : DW'(pd[k]);
      sq_next[k] = (pm[k] > DW'(SAT_LIMIT)) ? SAT_LIMIT : pm[k][16:0];
    end
    for (int k = 0; k < 4; k++) begin
      cxe[k] = PW'($signed(cfg.cx[k]));
      cye[k] = PW'($signed(cfg.cy[k]));
      if (cye[k] == py) flags_next.ycode[k] = ORI_COL;
      else if (cye[k] < py) flags_next.ycode[k] = ORI_POS;
      else flags_next.ycode[k] = ORI_NEG;
      flags_next.ray_on[k] = (cxe[k] >= px) && (cxe[k] <= far_x);
    end
    for (int i = 0; i < 4; i++) begin
      ex_next[i] = DW'(cxe[(i+1)%4]) - DW'(cxe[i]);
      ey_next[i] = DW'(cye[(i+1)%4]) - DW'(cye[i]);
      ax_next[i] = DW'(px) - DW'(cxe[(i+1)%4]);
      fx_next[i] = DW'(far_x) - DW'(cxe[(i+1)%4]);
      by_next[i] = DW'(py) - DW'(cye[(i+1)%4]);
      flags_next.onseg_p[i] = (px <= cxe[i] || px <= cxe[(i+1)%4]) &&
                              (px >= cxe[i] || px >= cxe[(i+1)%4]) &&
                              (py <= cye[i] || py <= cye[(i+1)%4]) &&
                              (py >= cye[i] || py >= cye[(i+1)%4]);
      flags_next.onseg_far[i] = (far_x <= cxe[i] || far_x <= cxe[(i+1)%4]) &&
                                (far_x >= cxe[i] || far_x >= cxe[(i+1)%4]) &&
                                (py <= cye[i] || py <= cye[(i+1)%4]) &&
                                (py >= cye[i] || py >= cye[(i+1)%4]);
    end
    // z first, then x,y straight or swapped
    flags_next.dims_ok = close_dim(dim_z, cfg.sz, cfg.bthr) &&
                         ((close_dim(dim_x, cfg.sx, cfg.bthr) &&
                           close_dim(dim_y, cfg.sy, cfg.bthr)) ||
                          (close_dim(dim_x, cfg.sy, cfg.bthr) &&
                           close_dim(dim_y, cfg.sx, cfg.bthr)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_mag <= sq_next;
      ex     <= ex_next;
      ey     <= ey_next;
      ax     <= ax_next;
      fx     <= fx_next;
      by     <= by_next;
      flags  <= flags_next;
    end
  end

endmodule
`default_nettype wire

[design/otm_mul.sv]
`default_nettype none
module otm_mul
  import otm_pkg::*;
#(
  parameter int COORD_BITS = OTM_COORD_BITS,
  localparam int CMAX = (COORD_BITS > 16) ? COORD_BITS : 16,
  localparam int DW = CMAX + 3,
  localparam int MW = 2 * DW
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  cfg_t                      cfg,
  input  wire logic [16:0]          sq_mag [3],
  input  wire logic signed [DW-1:0] ex [4],
  input  wire logic signed [DW-1:0] ey [4],
  input  wire logic signed [DW-1:0] ax [4],
  input  wire logic signed [DW-1:0] fx [4],
  input  wire logic signed [DW-1:0] by [4],
  output logic [33:0]               sq [3],
  output logic [31:0]               thr2,
  output logic signed [MW-1:0]      pa [4],
  output logic signed [MW-1:0]      pb [4],
  output logic signed [MW-1:0]      pc [4]
);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= 34'(sq_mag[k]) * 34'(sq_mag[k]);
      end
      thr2 <= 32'(cfg.dthr) * 32'(cfg.dthr);
      for (int i = 0; i < 4; i++) begin
        pa[i] <= MW'(ey[i]) * MW'(ax[i]);
        pb[i] <= MW'(ex[i]) * MW'(by[i]);
        pc[i] <= MW'(ey[i]) * MW'(fx[i]);
      end
    end
  end

endmodule
`default_nettype wire

[design/otm_eval.sv]
`default_nettype none
module otm_eval
  import otm_pkg::*;
#(
  parameter int COORD_BITS = OTM_COORD_BITS,
  localparam int CMAX = (COORD_BITS > 16) ? COORD_BITS : 16,
  localparam int MW = 2 * (CMAX + 3)
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [33:0]          sq [3],
  input  wire logic [31:0]          thr2,
  input  wire logic signed [MW-1:0] pa [4],
  input  wire logic signed [MW-1:0] pb [4],
  input  wire logic signed [MW-1:0] pc [4],
  input  geo_flags_t                flags,
  output eval_t                     ev
);

  logic [1:0] o1 [4], o2 [4], o3 [4], o4 [4];
  logic [34:0] sum;
  eval_t ev_next;

  function automatic logic [1:0] ori(input logic signed [MW-1:0] a,
                                     input logic signed [MW-1:0] b);
    if (a > b) return ORI_POS;
    else if (a < b) return ORI_NEG;
    else return ORI_COL;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      o1[i] = ori(pa[i], pb[i]);
      o2[i] = ori(pc[i], pb[i]);
      o3[i] = flags.ycode[i];
      o4[i] = flags.ycode[(i+1)%4];
      ev_next.hit[i] = (o1[i] != o2[i] && o3[i] != o4[i]) ||
                       (o1[i] == ORI_COL && flags.onseg_p[i]) ||
                       (o2[i] == ORI_COL && flags.onseg_far[i]) ||
                       (o3[i] == ORI_COL && flags.ray_on[i]) ||
                       (o4[i] == ORI_COL && flags.ray_on[(i+1)%4]);
      ev_next.col[i]   = (o1[i] == ORI_COL);
      ev_next.onseg[i] = flags.onseg_p[i];
    end
    sum = 35'(sq[0]) + 35'(sq[1]) + 35'(sq[2]);
    ev_next.point_ok = sum < 35'(thr2);
    ev_next.dims_ok  = flags.dims_ok;
  end

  always_ff @(posedge clk) begin
    if (en) ev <= ev_next;
  end

endmodule
`default_nettype wire

[design/object_target_match_filter.sv]
// object target match filter
// objects: one scene object per item (centre, box size, index, last mark).
// results: one item per object, the match flag for the configured mode
// plus the index and last mark copied through.
// configuration: cfg_write with cfg_index and cfg_data writes one register
// in a cycle; write only while no object is in flight.
// each object passes through the difference, multiply and compare stages,
// which feed the output register.
// throughput: one object per cycle unless stalled; every stage moves together.
// the pipeline moves whenever the output register is empty or being taken;
// when the receiver stalls with a result held, objects.ready drops and all
// stages hold, so nothing is lost or repeated.
// reset clears all configuration registers to zero (point mode) and empties
// the pipeline; objects.ready is low while rst is high.
`default_nettype none
module object_target_match_filter
  import otm_pkg::*;
#(
  parameter int COORD_BITS = OTM_COORD_BITS,
  localparam int CMAX = (COORD_BITS > 16) ? COORD_BITS : 16,
  localparam int DW = CMAX + 3,
  localparam int MW = 2 * DW
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  obj_if.sink                            objects,
  res_if.source                          results
);

  cfg_t cfg;
  logic en;
  logic v1, v2, v3;
  tag_t tag1, tag2, tag3;
  geo_flags_t flags1, flags2;
  eval_t ev;

  logic [16:0]          sq_mag [3];
  logic signed [DW-1:0] ex [4], ey [4], ax [4], fx [4], by [4];
  logic [33:0]          sq [3];
  logic [31:0]          thr2;
  logic signed [MW-1:0] pa [4], pb [4], pc [4];

  logic region_in, done, parity, matched_next;

  assign en = !results.valid || results.ready;
  assign objects.ready = en && !rst;

  otm_regs u_regs (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  otm_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk(clk), .en(en), .cfg(cfg),
    .pos_x(objects.pos_x), .pos_y(objects.pos_y), .pos_z(objects.pos_z),
    .dim_x(objects.dim_x), .dim_y(objects.dim_y), .dim_z(objects.dim_z),
    .sq_mag(sq_mag), .ex(ex), .ey(ey), .ax(ax), .fx(fx), .by(by), .flags(flags1)
  );

  otm_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk(clk), .en(en), .cfg(cfg), .sq_mag(sq_mag),
    .ex(ex), .ey(ey), .ax(ax), .fx(fx), .by(by),
    .sq(sq), .thr2(thr2), .pa(pa), .pb(pb), .pc(pc)
  );

  otm_eval #(.COORD_BITS(COORD_BITS)) u_eval (
    .clk(clk), .en(en), .sq(sq), .thr2(thr2), .pa(pa), .pb(pb), .pc(pc),
    .flags(flags2), .ev(ev)
  );

  // first crossing edge that is collinear with the point decides alone
  always_comb begin
    region_in = 1'b0;
    done      = 1'b0;
    parity    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!done && ev.hit[i]) begin
        if (ev.col[i]) begin
          region_in = ev.onseg[i];
          done      = 1'b1;
        end else begin
          parity = !parity;
        end
      end
    end
    if (!done) region_in = parity;
    unique case (cfg.mode)
      MODE_POINT:  matched_next = ev.point_ok;
      MODE_REGION: matched_next = region_in;
      MODE_DIMS:   matched_next = ev.dims_ok;
      default:     matched_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      results.valid <= 1'b0;
    end else if (en) begin
      v1 <= objects.valid;
      v2 <= v1;
      v3 <= v2;
      results.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1.index <= objects.object_index;
      tag1.last  <= objects.last_object;
      tag2   <= tag1;
      tag3   <= tag2;
      flags2 <= flags1;
      results.matched   <= matched_next;
      results.index_out <= tag3.index;
      results.last_out  <= tag3.last;
    end
  end

endmodule
`default_nettype wire

[tb/tb_object_target_match_filter.sv]
`default_nettype none
module tb_object_target_match_filter;
  import otm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        dim_x;
    logic [15:0]        dim_y;
    logic [15:0]        dim_z;
    logic [7:0]         index;
    logic               last;
  } scene_obj_t;

  typedef struct {
    logic       matched;
    logic [7:0] index;
    logic       last;
  } match_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  obj_if #(.COORD_BITS(16)) objects_bus ();
  res_if results_bus ();

  object_target_match_filter #(.COORD_BITS(16)) u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .objects(objects_bus), .results(results_bus)
  );

  always #5 clk = ~clk;

  // shadow copy of the block's registers
  logic [1:0]  sh_mode;
  logic [47:0] sh_target;
  logic [63:0] sh_c01;
  logic [63:0] sh_c23;
  logic [47:0] sh_sel;
  logic [15:0] sh_dthr;
  logic [15:0] sh_bthr;

  match_res_t pending_matches[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  function automatic longint sfield(logic [63:0] r, int k);
    logic signed [15:0] v;
    v = r[16*k +: 16];
    return longint'(v);
  endfunction

  function automatic logic [1:0] orient(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return ORI_COL;
    return (v > 0) ? ORI_POS : ORI_NEG;
  endfunction

  // q lies within the bounding box of p and r
  function automatic bit on_seg(longint px, longint py, longint qx, longint qy,
                                longint rx, longint ry);
    return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
           qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
  endfunction

  function automatic bit segs_cross(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy, longint dx, longint dy);
    logic [1:0] o1, o2, o3, o4;
    o1 = orient(ax, ay, bx, by, cx, cy);
    o2 = orient(ax, ay, bx, by, dx, dy);
    o3 = orient(cx, cy, dx, dy, ax, ay);
    o4 = orient(cx, cy, dx, dy, bx, by);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == ORI_COL && on_seg(ax, ay, cx, cy, bx, by)) return 1'b1;
    if (o2 == ORI_COL && on_seg(ax, ay, dx, dy, bx, by)) return 1'b1;
    if (o3 == ORI_COL && on_seg(cx, cy, ax, ay, dx, dy)) return 1'b1;
    if (o4 == ORI_COL && on_seg(cx, cy, bx, by, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit inside_region(longint px, longint py);
    longint cxs[4];
    longint cys[4];
    longint far_x;
    int n;
    int hits;
    hits = 0;
    far_x = 65536;
    for (int k = 0; k < 2; k++) begin
      cxs[k] = sfield(sh_c01, 2 * k);
      cys[k] = sfield(sh_c01, 2 * k + 1);
      cxs[k + 2] = sfield(sh_c23, 2 * k);
      cys[k + 2] = sfield(sh_c23, 2 * k + 1);
    end
    for (int i = 0; i < 4; i++) begin
      n = (i + 1) % 4;
      if (segs_cross(cxs[i], cys[i], cxs[n], cys[n], px, py, far_x, py)) begin
        if (orient(cxs[i], cys[i], px, py, cxs[n], cys[n]) == ORI_COL)
          return on_seg(cxs[i], cys[i], px, py, cxs[n], cys[n]);
        hits++;
      end
    end
    return hits[0];
  endfunction

  function automatic longint unsigned sat_square(longint d);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    if (m > 65536) m = 65536;
    return m * m;
  endfunction

  function automatic bit dim_close(logic [15:0] a, logic [15:0] b);
    return ((a > b) ? a - b : b - a) < sh_bthr;
  endfunction

  function automatic match_res_t predict_match(scene_obj_t o);
    match_res_t r;
    longint unsigned s;
    r.matched = 1'b0;
    r.index = o.index;
    r.last = o.last;
    case (sh_mode)
      MODE_POINT: begin
        s = sat_square(longint'(o.pos_x) - sfield(sh_target, 0)) +
            sat_square(longint'(o.pos_y) - sfield(sh_target, 1)) +
            sat_square(longint'(o.pos_z) - sfield(sh_target, 2));
        r.matched = s < longint'(sh_dthr) * longint'(sh_dthr);
      end
      MODE_REGION: r.matched = inside_region(o.pos_x, o.pos_y);
      MODE_DIMS: begin
        r.matched = dim_close(o.dim_z, sh_sel[47:32]) &&
                    ((dim_close(o.dim_x, sh_sel[15:0]) && dim_close(o.dim_y, sh_sel[31:16])) ||
                     (dim_close(o.dim_x, sh_sel[31:16]) && dim_close(o.dim_y, sh_sel[15:0])));
      end
      default: r.matched = 1'b0;
    endcase
    return r;
  endfunction

  initial begin
    objects_bus.valid = 1'b0;
    objects_bus.pos_x = '0;
    objects_bus.pos_y = '0;
    objects_bus.pos_z = '0;
    objects_bus.dim_x = '0;
    objects_bus.dim_y = '0;
    objects_bus.dim_z = '0;
    objects_bus.object_index = '0;
    objects_bus.last_object = 1'b0;
    results_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) results_bus.ready <= 1'b0;
    else results_bus.ready <= no_idle || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    match_res_t want;
    if (!rst && results_bus.valid && results_bus.ready) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected item matched=%0b index=%0d last=%0b", $time,
                 results_bus.matched, results_bus.index_out, results_bus.last_out);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        if (results_bus.matched !== want.matched) begin
          $display("%0t: matched expected %0b actual %0b", $time, want.matched,
                   results_bus.matched);
          errors++;
        end
        if (results_bus.index_out !== want.index) begin
          $display("%0t: index_out expected %0d actual %0d", $time, want.index,
                   results_bus.index_out);
          errors++;
        end
        if (results_bus.last_out !== want.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, want.last,
                   results_bus.last_out);
          errors++;
        end
      end
    end
  end

  // entered right after the clock rises; returns once objects.ready is seen high with the item driven
  task automatic send_obj(scene_obj_t o);
    if (!no_idle && $urandom_range(99) < 22) begin
      objects_bus.valid <= 1'b0;
      repeat (1 + $urandom_range(2)) @(posedge clk);
    end
    objects_bus.valid <= 1'b1;
    objects_bus.pos_x <= o.pos_x;
    objects_bus.pos_y <= o.pos_y;
    objects_bus.pos_z <= o.pos_z;
    objects_bus.dim_x <= o.dim_x;
    objects_bus.dim_y <= o.dim_y;
    objects_bus.dim_z <= o.dim_z;
    objects_bus.object_index <= o.index;
    objects_bus.last_object <= o.last;
    @(posedge clk);
    while (!objects_bus.ready) @(posedge clk);
    pending_matches = {pending_matches, predict_match(o)};
  endtask

  task automatic drain;
    objects_bus.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_MODE:   sh_mode = value[1:0];
      REG_TARGET: sh_target = value[47:0];
      REG_C01:    sh_c01 = value;
      REG_C23:    sh_c23 = value;
      REG_SEL:    sh_sel = value[47:0];
      REG_DTHR:   sh_dthr = value[15:0];
      REG_BTHR:   sh_bthr = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [63:0] pack_xy(int x0, int y0, int x1, int y1);
    logic [15:0] a, b, c, d;
    a = 16'(x0); b = 16'(y0); c = 16'(x1); d = 16'(y1);
    return {d, c, b, a};
  endfunction

  function automatic scene_obj_t make_obj(int x, int y, int z, int dx, int dy, int dz,
                                          int idx, bit last);
    scene_obj_t o;
    o.pos_x = 16'(x); o.pos_y = 16'(y); o.pos_z = 16'(z);
    o.dim_x = 16'(dx); o.dim_y = 16'(dy); o.dim_z = 16'(dz);
    o.index = 8'(idx); o.last = last;
    return o;
  endfunction

  function automatic scene_obj_t rand_obj(int spread);
    scene_obj_t o;
    o.pos_x = 16'($urandom); o.pos_y = 16'($urandom); o.pos_z = 16'($urandom);
    o.dim_x = 16'($urandom); o.dim_y = 16'($urandom); o.dim_z = 16'($urandom);
    o.index = 8'($urandom); o.last = $urandom_range(7) == 0;
    if (spread > 0 && $urandom_range(3) != 0) begin
      o.pos_x = 16'($signed($urandom_range(2 * spread)) - spread);
      o.pos_y = 16'($signed($urandom_range(2 * spread)) - spread);
      o.pos_z = 16'($signed($urandom_range(2 * spread)) - spread);
      o.dim_x = 16'(1000 + $urandom_range(spread));
      o.dim_y = 16'(1000 + $urandom_range(spread));
      o.dim_z = 16'(1000 + $urandom_range(spread));
    end
    return o;
  endfunction

  task automatic test_point;
    drain();
    write_reg(REG_MODE, 64'(MODE_POINT));
    // zero threshold never matches
    send_obj(make_obj(0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(REG_TARGET, pack_xy(100, -200, 300, 0));
    write_reg(REG_DTHR, 64'(50));
    send_obj(make_obj(100, -200, 300, 1, 2, 3, 1, 0));
    send_obj(make_obj(130, -160, 300, 1, 2, 3, 2, 0));
    send_obj(make_obj(130, -159, 300, 1, 2, 3, 3, 1));
    drain();
    write_reg(REG_TARGET, pack_xy(32767, 32767, 32767, 0));
    write_reg(REG_DTHR, 64'(16'hFFFF));
    // largest axis differences
    send_obj(make_obj(-32768, -32768, -32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 1));
    send_obj(make_obj(32767, 32767, 32767, 0, 0, 0, 128, 0));
  endtask

  task automatic test_region;
    drain();
    write_reg(REG_MODE, 64'(MODE_REGION));
    // all corners at the origin
    send_obj(make_obj(0, 0, 0, 0, 0, 0, 10, 0));
    send_obj(make_obj(1, 0, 0, 0, 0, 0, 11, 0));
    drain();
    write_reg(REG_C01, pack_xy(-100, -100, 100, -100));
    write_reg(REG_C23, pack_xy(100, 100, -100, 100));
    send_obj(make_obj(0, 0, 0, 0, 0, 0, 12, 0));
    send_obj(make_obj(100, 0, 0, 0, 0, 0, 13, 0));
    send_obj(make_obj(-100, 100, 0, 0, 0, 0, 14, 0));
    send_obj(make_obj(101, 0, 0, 0, 0, 0, 15, 0));
    send_obj(make_obj(-200, 100, 0, 0, 0, 0, 16, 0));
    send_obj(make_obj(32767, 0, 0, 0, 0, 0, 17, 1));
    drain();
    // collinear corners
    write_reg(REG_C01, pack_xy(-32768, -32768, 0, 0));
    write_reg(REG_C23, pack_xy(32767, 32767, 0, 0));
    send_obj(make_obj(5, 5, 0, 0, 0, 0, 18, 0));
    send_obj(make_obj(5, 6, 0, 0, 0, 0, 19, 1));
  endtask

  task automatic test_dims;
    drain();
    write_reg(REG_MODE, 64'(MODE_DIMS));
    write_reg(REG_SEL, 64'({16'd300, 16'd200, 16'd100}));
    write_reg(REG_BTHR, 64'(10));
    send_obj(make_obj(0, 0, 0, 100, 200, 300, 20, 0));
    send_obj(make_obj(0, 0, 0, 205, 95, 309, 21, 0));
    send_obj(make_obj(0, 0, 0, 100, 200, 310, 22, 0));
    send_obj(make_obj(0, 0, 0, 110, 200, 300, 23, 1));
    drain();
    write_reg(REG_BTHR, 64'(16'hFFFF));
    send_obj(make_obj(0, 0, 0, 16'hFFFF, 0, 0, 24, 0));
  endtask

  task automatic test_unused_mode;
    drain();
    write_reg(REG_MODE, 64'(MODE_UNUSED));
    send_obj(make_obj(0, 0, 0, 100, 200, 300, 25, 1));
  endtask

  task automatic test_random;
    int spread;
    int span;
    for (int phase = 0; phase < 19; phase++) begin
      drain();
      no_idle = (phase == 7);
      spread = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 400 : 30000);
      span = (spread == 0) ? 0 : spread;
      write_reg(REG_MODE, 64'((phase % 8 == 7) ? MODE_UNUSED : 2'(phase % 3)));
      if ($urandom_range(1)) write_reg(REG_TARGET, {$urandom, $urandom});
      else write_reg(REG_TARGET, pack_xy($urandom_range(200), $urandom_range(200),
                                         $urandom_range(200), 0));
      write_reg(REG_DTHR, 64'((spread == 0) ? $urandom : $urandom_range(800)));
      if (spread == 0) begin
        write_reg(REG_C01, {$urandom, $urandom});
        write_reg(REG_C23, {$urandom, $urandom});
      end else begin
        // convex-ish quad around the origin with random jitter
        write_reg(REG_C01, pack_xy(-$urandom_range(span), -$urandom_range(span),
                                   $urandom_range(span), -$urandom_range(span)));
        write_reg(REG_C23, pack_xy($urandom_range(span), $urandom_range(span),
                                   -$urandom_range(span), $urandom_range(span)));
      end
      write_reg(REG_SEL, 64'({16'(1000 + $urandom_range(400)), 16'(1000 + $urandom_range(400)),
                              16'(1000 + $urandom_range(400))}));
      write_reg(REG_BTHR, 64'((spread == 0) ? $urandom : $urandom_range(300)));
      for (int k = 0; k < 50; k++) begin
        // one pause mid stream until every result is back
        if (phase == 3 && k == 25) drain();
        send_obj(rand_obj(spread));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    sh_mode = '0; sh_target = '0; sh_c01 = '0; sh_c23 = '0;
    sh_sel = '0; sh_dthr = '0; sh_bthr = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_point();
    test_region();
    test_dims();
    test_unused_mode();
    test_random();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_matches.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
design/otm_pkg.sv
design/otm_if.sv
design/otm_regs.sv
design/otm_diff.sv
design/otm_mul.sv
design/otm_eval.sv
design/object_target_match_filter.sv
tb/tb_object_target_match_filter.sv
